/* src/bcc_pkg.sv */
// Shared types and constants for the barycentric coordinate block.
// Used by barycentric_coords_3d and its port checker; depends on nothing.
package bcc_pkg;

    // Integer bits of a weight above its fraction (sign included)
    localparam int WEIGHT_INT_BITS = 4;

    // Dot product codes: d00, d01, d11, d0p, d1p
    localparam int NUM_DOTS = 5;
    // Second-level products: det terms, first numerator terms, second numerator terms
    localparam int NUM_PRODS = 6;

    // Operand pairs of the second-level products, as dot product codes
    localparam int PROD_A [NUM_PRODS] = '{0, 1, 2, 1, 0, 1};
    localparam int PROD_B [NUM_PRODS] = '{2, 1, 3, 4, 4, 3};

    // Per-item flags carried through the divider stages
    typedef struct packed {
        logic neg_first;
        logic neg_second;
        logic in_tri;
        logic degen;
    } bcc_flags_t;

endpackage

/* src/barycentric_coords_3d.sv */
// Barycentric weights of a 3D point against a triangle, fully pipelined.
// Depends on bcc_pkg (flag struct, product operand tables, weight int bits).
//
// One item enters and one result leaves per clock while the pipeline is not
// stalled. QW = 4*COORD_WIDTH + WEIGHT_FRAC + 10 is the length of the
// one-bit-per-stage restoring divider that forms both weights.
// The whole pipeline advances together; a two-entry output buffer
// (output register plus skid) absorbs one result while the consumer stalls,
// after which in_ready drops until the skid entry drains.
module barycentric_coords_3d
    import bcc_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int WEIGHT_FRAC = 16
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic signed [COORD_WIDTH-1:0]                 first_x,
    input  logic signed [COORD_WIDTH-1:0]                 first_y,
    input  logic signed [COORD_WIDTH-1:0]                 first_z,
    input  logic signed [COORD_WIDTH-1:0]                 second_x,
    input  logic signed [COORD_WIDTH-1:0]                 second_y,
    input  logic signed [COORD_WIDTH-1:0]                 second_z,
    input  logic signed [COORD_WIDTH-1:0]                 third_x,
    input  logic signed [COORD_WIDTH-1:0]                 third_y,
    input  logic signed [COORD_WIDTH-1:0]                 third_z,
    input  logic signed [COORD_WIDTH-1:0]                 query_x,
    input  logic signed [COORD_WIDTH-1:0]                 query_y,
    input  logic signed [COORD_WIDTH-1:0]                 query_z,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic signed [WEIGHT_FRAC+WEIGHT_INT_BITS-1:0] weight_first,
    output logic signed [WEIGHT_FRAC+WEIGHT_INT_BITS-1:0] weight_second,
    output logic signed [WEIGHT_FRAC+WEIGHT_INT_BITS-1:0] weight_third,
    output logic                                          inside_res,
    output logic                                          degenerate
);

    localparam int WW   = WEIGHT_FRAC + WEIGHT_INT_BITS;
    localparam int DW   = COORD_WIDTH + 1;     // coordinate difference
    localparam int MW   = 2 * DW;              // coordinate product
    localparam int DOTW = MW + 2;              // dot product
    localparam int HL   = DOTW / 2;            // low half of a split operand
    localparam int HH   = DOTW - HL;           // high half of a split operand
    localparam int PW   = 2 * DOTW;            // dot by dot product
    localparam int NW   = PW + 1;              // determinant and numerators
    localparam int QW   = NW + WEIGHT_FRAC + 1;// dividend and quotient
    localparam int RW   = NW + 1;              // partial remainder
    localparam int XW   = QW + 3;              // weight before saturation
    localparam int FRONT = 6;                  // stages ahead of the divider

    localparam logic signed [XW-1:0] ONE_Q   = XW'(1) << WEIGHT_FRAC;
    localparam logic signed [XW-1:0] SAT_MAX = XW'((1 << (WW - 1)) - 1);
    localparam logic signed [XW-1:0] SAT_MIN = -SAT_MAX - XW'(1);

    // Clamp a wide weight to the output range
    function automatic logic signed [WW-1:0] sat(input logic signed [XW-1:0] s);
        logic signed [WW-1:0] r;
        if (s > SAT_MAX) begin
            r = SAT_MAX[WW-1:0];
        end
        else if (s < SAT_MIN) begin
            r = SAT_MIN[WW-1:0];
        end
        else begin
            r = s[WW-1:0];
        end
        return r;
    endfunction

    // Pipeline control
    logic               en;
    logic [FRONT-1:0]   v_reg;
    logic [QW:0]        div_v_reg;
    logic               skid_v_reg;
    logic               out_v_reg;

    // Front stage payload
    logic signed [DW-1:0]   e0_reg [3];
    logic signed [DW-1:0]   e1_reg [3];
    logic signed [DW-1:0]   p_reg  [3];
    logic signed [DW-1:0]   e0_next [3];
    logic signed [DW-1:0]   e1_next [3];
    logic signed [DW-1:0]   p_next  [3];
    logic signed [MW-1:0]   m_reg  [NUM_DOTS][3];
    logic signed [MW-1:0]   m_next [NUM_DOTS][3];
    logic signed [DOTW-1:0] dot_reg  [NUM_DOTS];
    logic signed [DOTW-1:0] dot_next [NUM_DOTS];
    logic signed [HL+DOTW:0]   lo_reg  [NUM_PRODS];
    logic signed [HL+DOTW:0]   lo_next [NUM_PRODS];
    logic signed [HH+DOTW-1:0] hi_reg  [NUM_PRODS];
    logic signed [HH+DOTW-1:0] hi_next [NUM_PRODS];
    logic signed [PW-1:0]   prod_reg  [NUM_PRODS];
    logic signed [PW-1:0]   prod_next [NUM_PRODS];
    logic signed [NW-1:0]   det_reg, n1_reg, n2_reg;
    logic signed [NW-1:0]   det_next, n1_next, n2_next;

    // Divider payload; index 0 is the set-up stage
    logic [RW-1:0]  rem_reg  [QW+1][2];
    logic [QW-1:0]  nq_reg   [QW+1][2];
    logic [NW-1:0]  den_reg  [QW+1];
    bcc_flags_t     flag_reg [QW+1];
    logic [RW-1:0]  rem_next [1:QW][2];
    logic [QW-1:0]  nq_next  [1:QW][2];

    // Set-up stage values
    logic [RW-1:0]          rem0_next [2];
    logic [QW-1:0]          nq0_next  [2];
    logic [NW-1:0]          den0_next;
    bcc_flags_t             flag0_next;
    logic signed [NW+1:0]   rest;
    logic [NW-1:0]          det_u, mag1, mag2;

    // Final result
    logic signed [QW:0]     w1, w2;
    logic signed [XW-1:0]   w3;
    logic signed [WW-1:0]   res_w1, res_w2, res_w3;
    logic                   res_inside, res_degen, res_valid;

    // Output buffer
    logic signed [WW-1:0]   out_w1_reg, out_w2_reg, out_w3_reg;
    logic                   out_in_reg, out_dg_reg;
    logic signed [WW-1:0]   skid_w1_reg, skid_w2_reg, skid_w3_reg;
    logic                   skid_in_reg, skid_dg_reg;

    // Advance the whole pipeline while the skid entry is free
    assign en        = !skid_v_reg;
    assign in_ready  = en;
    assign res_valid = div_v_reg[QW] && en;

    // Edge vectors and offset from the reference vertex
    always_comb
    begin
        e0_next[0] = DW'(first_x)  - DW'(third_x);
        e0_next[1] = DW'(first_y)  - DW'(third_y);
        e0_next[2] = DW'(first_z)  - DW'(third_z);
        e1_next[0] = DW'(second_x) - DW'(third_x);
        e1_next[1] = DW'(second_y) - DW'(third_y);
        e1_next[2] = DW'(second_z) - DW'(third_z);
        p_next[0]  = DW'(query_x)  - DW'(third_x);
        p_next[1]  = DW'(query_y)  - DW'(third_y);
        p_next[2]  = DW'(query_z)  - DW'(third_z);
    end

    // Component products of the five dot products
    always_comb
    begin
        for (int j = 0; j < 3; j++) begin
            m_next[0][j] = e0_reg[j] * e0_reg[j];
            m_next[1][j] = e0_reg[j] * e1_reg[j];
            m_next[2][j] = e1_reg[j] * e1_reg[j];
            m_next[3][j] = e0_reg[j] * p_reg[j];
            m_next[4][j] = e1_reg[j] * p_reg[j];
        end
    end

    // Sum components
    always_comb
    begin
        for (int i = 0; i < NUM_DOTS; i++) begin
            dot_next[i] = DOTW'(m_reg[i][0]) + DOTW'(m_reg[i][1]) + DOTW'(m_reg[i][2]);
        end
    end

    // Partial products: split the first operand into halves
    always_comb
    begin
        for (int i = 0; i < NUM_PRODS; i++) begin
            lo_next[i] = $signed({1'b0, dot_reg[PROD_A[i]][HL-1:0]}) * dot_reg[PROD_B[i]];
            hi_next[i] = $signed(dot_reg[PROD_A[i]][DOTW-1:HL]) * dot_reg[PROD_B[i]];
        end
    end

    // Combine halves
    always_comb
    begin
        for (int i = 0; i < NUM_PRODS; i++) begin
            prod_next[i] = (PW'(hi_reg[i]) <<< HL) + PW'(lo_reg[i]);
        end
    end

    // Gram determinant and the two numerators
    always_comb
    begin
        det_next = NW'(prod_reg[0]) - NW'(prod_reg[1]);
        n1_next  = NW'(prod_reg[2]) - NW'(prod_reg[3]);
        n2_next  = NW'(prod_reg[4]) - NW'(prod_reg[5]);
    end

    // Set up rounded division: (|n| * 2^(F+1) + det) / (2 * det)
    always_comb
    begin
        det_u = det_reg;
        rest  = (NW+2)'(det_reg) - (NW+2)'(n1_reg) - (NW+2)'(n2_reg);
        mag1  = n1_reg[NW-1] ? NW'(-n1_reg) : NW'(n1_reg);
        mag2  = n2_reg[NW-1] ? NW'(-n2_reg) : NW'(n2_reg);
        flag0_next.neg_first  = n1_reg[NW-1];
        flag0_next.neg_second = n2_reg[NW-1];
        flag0_next.in_tri     = !n1_reg[NW-1] && !n2_reg[NW-1] && !rest[NW+1] && (rest != '0);
        flag0_next.degen      = (det_reg == '0);
        nq0_next[0]  = (QW'(mag1) << (WEIGHT_FRAC + 1)) + QW'(det_u);
        nq0_next[1]  = (QW'(mag2) << (WEIGHT_FRAC + 1)) + QW'(det_u);
        rem0_next[0] = '0;
        rem0_next[1] = '0;
        den0_next    = {det_u[NW-2:0], 1'b0};
    end

    // Restoring division, one quotient bit per stage; quotient bits
    // shift in as dividend bits shift out
    always_comb
    begin
        logic [RW-1:0] sh;
        logic          ge;
        for (int k = 1; k <= QW; k++) begin
            for (int j = 0; j < 2; j++) begin
                sh = {rem_reg[k-1][j][NW-1:0], nq_reg[k-1][j][QW-1]};
                ge = (sh >= {1'b0, den_reg[k-1]});
                rem_next[k][j] = ge ? (sh - {1'b0, den_reg[k-1]}) : sh;
                nq_next[k][j]  = {nq_reg[k-1][j][QW-2:0], ge};
            end
        end
    end

    // Apply signs, form the third weight, saturate
    always_comb
    begin
        w1 = flag_reg[QW].neg_first  ? -$signed({1'b0, nq_reg[QW][0]})
                                     :  $signed({1'b0, nq_reg[QW][0]});
        w2 = flag_reg[QW].neg_second ? -$signed({1'b0, nq_reg[QW][1]})
                                     :  $signed({1'b0, nq_reg[QW][1]});
        w3 = ONE_Q - XW'(w1) - XW'(w2);
        res_degen  = flag_reg[QW].degen;
        res_inside = flag_reg[QW].in_tri && !flag_reg[QW].degen;
        if (flag_reg[QW].degen) begin
            res_w1 = '0;
            res_w2 = '0;
            res_w3 = '0;
        end
        else begin
            res_w1 = sat(XW'(w1));
            res_w2 = sat(XW'(w2));
            res_w3 = sat(w3);
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg     <= '0;
            div_v_reg <= '0;
        end
        else if (en) begin
            v_reg     <= {v_reg[FRONT-2:0], in_valid};
            div_v_reg <= {div_v_reg[QW-1:0], v_reg[FRONT-1]};
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en) begin
            e0_reg   <= e0_next;
            e1_reg   <= e1_next;
            p_reg    <= p_next;
            m_reg    <= m_next;
            dot_reg  <= dot_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            prod_reg <= prod_next;
            det_reg  <= det_next;
            n1_reg   <= n1_next;
            n2_reg   <= n2_next;
            rem_reg[0]  <= rem0_next;
            nq_reg[0]   <= nq0_next;
            den_reg[0]  <= den0_next;
            flag_reg[0] <= flag0_next;
            for (int k = 1; k <= QW; k++) begin
                rem_reg[k]  <= rem_next[k];
                nq_reg[k]   <= nq_next[k];
                den_reg[k]  <= den_reg[k-1];
                flag_reg[k] <= flag_reg[k-1];
            end
        end
    end

    // Output register and skid: valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || out_ready) begin
            out_v_reg  <= skid_v_reg || res_valid;
            skid_v_reg <= 1'b0;
        end
        else if (res_valid) begin
            skid_v_reg <= 1'b1;
        end
    end

    // Output register and skid: payload
    always_ff @(posedge clk)
    begin
        if (!out_v_reg || out_ready) begin
            if (skid_v_reg) begin
                out_w1_reg <= skid_w1_reg;
                out_w2_reg <= skid_w2_reg;
                out_w3_reg <= skid_w3_reg;
                out_in_reg <= skid_in_reg;
                out_dg_reg <= skid_dg_reg;
            end
            else begin
                out_w1_reg <= res_w1;
                out_w2_reg <= res_w2;
                out_w3_reg <= res_w3;
                out_in_reg <= res_inside;
                out_dg_reg <= res_degen;
            end
        end
        else if (res_valid) begin
            skid_w1_reg <= res_w1;
            skid_w2_reg <= res_w2;
            skid_w3_reg <= res_w3;
            skid_in_reg <= res_inside;
            skid_dg_reg <= res_degen;
        end
    end

    assign out_valid     = out_v_reg;
    assign weight_first  = out_w1_reg;
    assign weight_second = out_w2_reg;
    assign weight_third  = out_w3_reg;
    assign inside_res    = out_in_reg;
    assign degenerate    = out_dg_reg;

endmodule

/* src/bcc_checker.sv */
// Port-level checks for barycentric_coords_3d, attached by bind.
// Depends on bcc_pkg for the weight integer width.
module bcc_checker
    import bcc_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int WEIGHT_FRAC = 16
)
(
    input logic                                          clk,
    input logic                                          rst_n,
    input logic                                          in_valid,
    input logic                                          in_ready,
    input logic signed [COORD_WIDTH-1:0]                 first_x,
    input logic signed [COORD_WIDTH-1:0]                 first_y,
    input logic signed [COORD_WIDTH-1:0]                 first_z,
    input logic signed [COORD_WIDTH-1:0]                 second_x,
    input logic signed [COORD_WIDTH-1:0]                 second_y,
    input logic signed [COORD_WIDTH-1:0]                 second_z,
    input logic signed [COORD_WIDTH-1:0]                 third_x,
    input logic signed [COORD_WIDTH-1:0]                 third_y,
    input logic signed [COORD_WIDTH-1:0]                 third_z,
    input logic signed [COORD_WIDTH-1:0]                 query_x,
    input logic signed [COORD_WIDTH-1:0]                 query_y,
    input logic signed [COORD_WIDTH-1:0]                 query_z,
    input logic                                          out_valid,
    input logic                                          out_ready,
    input logic signed [WEIGHT_FRAC+WEIGHT_INT_BITS-1:0] weight_first,
    input logic signed [WEIGHT_FRAC+WEIGHT_INT_BITS-1:0] weight_second,
    input logic signed [WEIGHT_FRAC+WEIGHT_INT_BITS-1:0] weight_third,
    input logic                                          inside_res,
    input logic                                          degenerate
);

    localparam int WW = WEIGHT_FRAC + WEIGHT_INT_BITS;
    localparam logic signed [WW-1:0] ONE_W = WW'(1) << WEIGHT_FRAC;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(weight_first)
            && $stable(weight_second) && $stable(weight_third)
            && $stable(inside_res) && $stable(degenerate))
        else $error("stalled result changed");

    // Drop weights on a zero determinant
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> weight_first == '0 && weight_second == '0
            && weight_third == '0 && !inside_res)
        else $error("degenerate result carries weights");

    // An inside point has first two weights in [0, 1]
    a_inside_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_res |-> weight_first >= 0 && weight_second >= 0
            && weight_first <= ONE_W && weight_second <= ONE_W)
        else $error("inside flag with weight out of range");

    // Input side stays open while the output is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

endmodule

bind barycentric_coords_3d bcc_checker #(
    .COORD_WIDTH(COORD_WIDTH),
    .WEIGHT_FRAC(WEIGHT_FRAC)
) u_bcc_checker (.*);
